FILE: hw/rtl/mfb_pkg.sv
// Shared constants, types and glyph table for the monochrome framebuffer text renderer.
`timescale 1ns / 1ps
`default_nettype none
package mfb_pkg;

  localparam int SCREEN_WIDTH  = 172;
  localparam int SCREEN_HEIGHT = 320;
  localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_HEIGHT * ROW_BYTES;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int COL_W         = $clog2(SCREEN_WIDTH);
  localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
  // Glyph cursor reach: 1023 + 7*255 + 254 fits in 12 bits
  localparam int COORD_W       = 12;

  localparam logic [7:0] GLYPH_FIRST = 8'h20;
  localparam logic [7:0] GLYPH_LAST  = 8'h7E;

  // Register indexes on the configuration port
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef enum logic [2:0] {
    OP_FILL   = 3'd0,
    OP_SET    = 3'd1,
    OP_GET    = 3'd2,
    OP_LINE   = 3'd3,
    OP_SCALED = 3'd4,
    OP_SCAN   = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_PT_RD,
    S_PT_WR,
    S_GL_CHK,
    S_GL_RD,
    S_GL_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic sweep_wr;
    logic sweep_zero;
    logic pix_rd;
    logic pix_wr;
    logic pix_sample;
    logic glyph_step;
    logic scan_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       sweep_last;
    logic       point_on;
    logic       line_ok;
    logic       scale_zero;
    logic       glyph_last;
  } stat_t;

  // Six columns per glyph, column 0 in the top byte; bit r of a column is glyph row r
  localparam logic [47:0] GLYPH_ROM [95] = '{
    48'h000000000000, 48'h00005F000000, 48'h000700070000, 48'h147F147F1400,
    48'h242A7F2A1200, 48'h231308646200, 48'h364955225000, 48'h000503000000,
    48'h001C22410000, 48'h0041221C0000, 48'h082A1C2A0800, 48'h08083E080800,
    48'h005030000000, 48'h080808080800, 48'h006060000000, 48'h201008040200,
    48'h3E5149453E00, 48'h00427F400000, 48'h426151494600, 48'h2141454B3100,
    48'h1814127F1000, 48'h274545453900, 48'h3C4A49493000, 48'h017109050300,
    48'h364949493600, 48'h064949291E00, 48'h003636000000, 48'h005636000000,
    48'h000814224100, 48'h141414141400, 48'h412214080000, 48'h020151090600,
    48'h324979413E00, 48'h7E1111117E00, 48'h7F4949493600, 48'h3E4141412200,
    48'h7F4141221C00, 48'h7F4949494100, 48'h7F0909010100, 48'h3E4141513200,
    48'h7F0808087F00, 48'h00417F410000, 48'h2040413F0100, 48'h7F0814224100,
    48'h7F4040404000, 48'h7F0204027F00, 48'h7F0408107F00, 48'h3E4141413E00,
    48'h7F0909090600, 48'h3E4151215E00, 48'h7F0919294600, 48'h464949493100,
    48'h01017F010100, 48'h3F4040403F00, 48'h1F2040201F00, 48'h7F2018207F00,
    48'h631408146300, 48'h030478040300, 48'h615149454300, 48'h00007F414100,
    48'h020408102000, 48'h41417F000000, 48'h040201020400, 48'h404040404000,
    48'h000102040000, 48'h205454547800, 48'h7F4844443800, 48'h384444442000,
    48'h384444487F00, 48'h385454541800, 48'h087E09010200, 48'h081454543C00,
    48'h7F0804047800, 48'h00447D400000, 48'h2040443D0000, 48'h007F10284400,
    48'h00417F400000, 48'h7C0418047800, 48'h7C0804047800, 48'h384444443800,
    48'h7C1414140800, 48'h081414187C00, 48'h7C0804040800, 48'h485454542000,
    48'h043F44402000, 48'h3C4040207C00, 48'h1C2040201C00, 48'h3C4030403C00,
    48'h442810284400, 48'h0C5050503C00, 48'h4464544C4400, 48'h000836410000,
    48'h00007F000000, 48'h004136080000, 48'h080408100800
  };

  // Column bits of a glyph; non-printable codes and columns past five read as blank
  function automatic logic [7:0] glyph_bits(input logic [7:0] code, input logic [2:0] col);
    logic [6:0]  idx;
    logic [47:0] ent;
    logic [7:0]  res;
    idx = 7'(code - GLYPH_FIRST);
    res = 8'h00;
    if (code >= GLYPH_FIRST && code <= GLYPH_LAST && col < 3'd6) begin
      ent = GLYPH_ROM[idx];
      res = ent[6'(47 - 8 * int'(col)) -: 8];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mfb_ctrl.sv
// Controller state machine: sequences sweeps, point accesses, glyph walks and result beats.
`timescale 1ns / 1ps
`default_nettype none
module mfb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire mfb_pkg::stat_t st,
  output mfb_pkg::cmd_t       cmd
);

  mfb_pkg::state_t state, state_next;
  logic            out_valid_next;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mfb_pkg::S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      mfb_pkg::S_CLEAR: begin
        cmd.sweep_wr   = 1'b1;
        cmd.sweep_zero = 1'b1;
        if (st.sweep_last) state_next = mfb_pkg::S_IDLE;
      end
      mfb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = mfb_pkg::S_DECODE;
        end
      end
      mfb_pkg::S_DECODE: begin
        state_next = mfb_pkg::S_DONE;
        if (st.op == mfb_pkg::OP_FILL) begin
          state_next = mfb_pkg::S_FILL;
        end else if (st.op == mfb_pkg::OP_SET || st.op == mfb_pkg::OP_GET) begin
          if (st.point_on) state_next = mfb_pkg::S_PT_RD;
        end else if (st.op == mfb_pkg::OP_LINE) begin
          if (st.line_ok) state_next = mfb_pkg::S_GL_CHK;
        end else if (st.op == mfb_pkg::OP_SCALED) begin
          if (!st.scale_zero) state_next = mfb_pkg::S_GL_CHK;
        end else if (st.op == mfb_pkg::OP_SCAN) begin
          state_next = mfb_pkg::S_PT_RD;
        end
      end
      mfb_pkg::S_FILL: begin
        cmd.sweep_wr = 1'b1;
        if (st.sweep_last) state_next = mfb_pkg::S_DONE;
      end
      mfb_pkg::S_PT_RD: begin
        cmd.pix_rd = 1'b1;
        state_next = mfb_pkg::S_PT_WR;
      end
      mfb_pkg::S_PT_WR: begin
        cmd.pix_wr     = (st.op == mfb_pkg::OP_SET);
        cmd.pix_sample = (st.op == mfb_pkg::OP_GET) || (st.op == mfb_pkg::OP_SCAN);
        cmd.scan_step  = (st.op == mfb_pkg::OP_SCAN);
        state_next     = mfb_pkg::S_DONE;
      end
      mfb_pkg::S_GL_CHK: begin
        if (st.point_on) begin
          state_next = mfb_pkg::S_GL_RD;
        end else begin
          cmd.glyph_step = 1'b1;
          if (st.glyph_last) state_next = mfb_pkg::S_DONE;
        end
      end
      mfb_pkg::S_GL_RD: begin
        cmd.pix_rd = 1'b1;
        state_next = mfb_pkg::S_GL_WR;
      end
      mfb_pkg::S_GL_WR: begin
        cmd.pix_wr     = 1'b1;
        cmd.glyph_step = 1'b1;
        state_next     = st.glyph_last ? mfb_pkg::S_DONE : mfb_pkg::S_GL_CHK;
      end
      mfb_pkg::S_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = mfb_pkg::S_IDLE;
        end
      end
      default: state_next = mfb_pkg::S_IDLE;
    endcase
  end

  // Hold the result beat until taken
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mfb_datapath.sv
// Datapath: frame store memory, glyph cursor, scan position and result registers.
`timescale 1ns / 1ps
`default_nettype none
module mfb_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mfb_pkg::cmd_t                 cmd,
  output mfb_pkg::stat_t                     st,
  input  wire logic [2:0]                    opcode,
  input  wire logic [9:0]                    pos_x,
  input  wire logic [9:0]                    pos_y,
  input  wire logic [6:0]                    text_line,
  input  wire logic                          pixel_value,
  input  wire logic [7:0]                    char_code,
  input  wire logic [7:0]                    scale,
  input  wire logic [15:0]                   fg_color,
  input  wire logic [15:0]                   bg_color,
  output logic                               read_bit,
  output logic [15:0]                        pixel,
  output logic                               frame_end
);

  localparam int CW = mfb_pkg::COORD_W;
  localparam int AW = mfb_pkg::ADDR_W;

  logic [7:0]  mem [mfb_pkg::STORE_BYTES];
  logic [7:0]  rdata;

  logic [2:0]  op;
  logic        val;
  logic [7:0]  code;
  logic [7:0]  s;
  logic [9:0]  ybase;
  logic [CW-1:0] xb, yb;
  logic [2:0]  gc, gr;
  logic [7:0]  dx, dy;
  logic [AW-1:0] sweep;
  logic [mfb_pkg::COL_W-1:0] scan_col;
  logic [mfb_pkg::ROW_W-1:0] scan_row;
  logic        sample_bit;
  logic        wrap_flag;

  logic [9:0]    ybase_in;
  logic [CW-1:0] px, py;
  logic          off_x, off_y, dx_last, dy_last, block_end;
  logic [AW-1:0] pix_addr, scan_addr, addr;
  logic [7:0]    wdata, mask;
  logic [2:0]    bit_col;
  logic          gbit, wbit;
  logic [7:0]    gcol;
  logic          scan_end;

  assign ybase_in = (opcode == mfb_pkg::OP_LINE) ? {text_line, 3'b000} : pos_y;

  // Current pixel of the cursor
  assign px    = xb + CW'(dx);
  assign py    = yb + CW'(dy);
  assign off_x = px >= CW'(mfb_pkg::SCREEN_WIDTH);
  assign off_y = py >= CW'(mfb_pkg::SCREEN_HEIGHT);
  assign dx_last   = (9'(dx) + 9'd1) == 9'(s);
  assign dy_last   = (9'(dy) + 9'd1) == 9'(s);
  assign block_end = off_y || ((off_x || dx_last) && dy_last);
  assign scan_end  = (scan_col == mfb_pkg::COL_W'(mfb_pkg::SCREEN_WIDTH - 1))
                  && (scan_row == mfb_pkg::ROW_W'(mfb_pkg::SCREEN_HEIGHT - 1));

  // Status back to the controller
  always_comb begin
    st.op         = op;
    st.sweep_last = sweep == AW'(mfb_pkg::STORE_BYTES - 1);
    st.point_on   = !off_x && !off_y;
    st.line_ok    = (xb + CW'(6) <= CW'(mfb_pkg::SCREEN_WIDTH))
                 && (CW'(ybase) + CW'(8) <= CW'(mfb_pkg::SCREEN_HEIGHT))
                 && (code >= mfb_pkg::GLYPH_FIRST) && (code <= mfb_pkg::GLYPH_LAST);
    st.scale_zero = s == 8'd0;
    st.glyph_last = block_end && gc == 3'd5 && gr == 3'd7;
  end

  // Byte addresses of the cursor pixel and the scan pixel
  assign pix_addr  = AW'(py) * AW'(mfb_pkg::ROW_BYTES) + AW'(px >> 3);
  assign scan_addr = AW'(scan_row) * AW'(mfb_pkg::ROW_BYTES) + AW'(scan_col >> 3);

  always_comb begin
    if (cmd.sweep_wr) addr = sweep;
    else if (op == mfb_pkg::OP_SCAN) addr = scan_addr;
    else addr = pix_addr;
  end

  // Read-modify-write byte
  assign gcol    = mfb_pkg::glyph_bits(code, gc);
  assign gbit    = gcol[gr];
  assign wbit    = (op == mfb_pkg::OP_SET) ? val : gbit;
  assign mask    = 8'h80 >> px[2:0];
  assign bit_col = (op == mfb_pkg::OP_SCAN) ? scan_col[2:0] : px[2:0];

  always_comb begin
    if (cmd.sweep_wr) wdata = (cmd.sweep_zero || !val) ? 8'h00 : 8'hFF;
    else if (wbit) wdata = rdata | mask;
    else wdata = rdata & ~mask;
  end

  // Frame store
  always_ff @(posedge clk) begin
    if (cmd.sweep_wr || cmd.pix_wr) mem[addr] <= wdata;
    if (cmd.pix_rd) rdata <= mem[addr];
  end

  // Sweep counter and scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep    <= '0;
      scan_col <= '0;
      scan_row <= '0;
    end else begin
      if (cmd.sweep_wr) begin
        sweep <= (sweep == AW'(mfb_pkg::STORE_BYTES - 1)) ? '0 : sweep + AW'(1);
      end
      if (cmd.scan_step) begin
        if (scan_col == mfb_pkg::COL_W'(mfb_pkg::SCREEN_WIDTH - 1)) begin
          scan_col <= '0;
          if (scan_row == mfb_pkg::ROW_W'(mfb_pkg::SCREEN_HEIGHT - 1)) scan_row <= '0;
          else scan_row <= scan_row + 1'b1;
        end else begin
          scan_col <= scan_col + 1'b1;
        end
      end
    end
  end

  // Capture the item and walk the glyph cursor
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op         <= opcode;
      val        <= pixel_value;
      code       <= char_code;
      s          <= (opcode == mfb_pkg::OP_LINE) ? 8'd1 : scale;
      ybase      <= ybase_in;
      xb         <= CW'(pos_x);
      yb         <= CW'(ybase_in);
      gc         <= '0;
      gr         <= '0;
      dx         <= '0;
      dy         <= '0;
      sample_bit <= 1'b0;
      wrap_flag  <= 1'b0;
    end else begin
      if (cmd.pix_sample) begin
        sample_bit <= rdata[3'd7 - bit_col];
        wrap_flag  <= scan_end;
      end
      if (cmd.glyph_step) begin
        if (block_end) begin
          dx <= '0;
          dy <= '0;
          if (gr == 3'd7) begin
            gr <= '0;
            gc <= gc + 1'b1;
            yb <= CW'(ybase);
            xb <= xb + CW'(s);
          end else begin
            gr <= gr + 1'b1;
            yb <= yb + CW'(s);
          end
        end else if (off_x || dx_last) begin
          dx <= '0;
          dy <= dy + 1'b1;
        end else begin
          dx <= dx + 1'b1;
        end
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_bit  <= (op == mfb_pkg::OP_GET) && sample_bit;
      pixel     <= (op == mfb_pkg::OP_SCAN) ? (sample_bit ? fg_color : bg_color) : 16'h0000;
      frame_end <= (op == mfb_pkg::OP_SCAN) && wrap_flag;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mono_framebuffer_text_render_unit.sv
// Top level of the monochrome framebuffer text renderer: register port, controller, datapath.
`timescale 1ns / 1ps
`default_nettype none
// A 172x320 one-bit framebuffer held in a single-port byte memory, with a 6x8 glyph
// table for ASCII 0x20..0x7E. After reset the block clears the store, one byte per
// cycle, before it takes the first item (register writes are taken throughout). Each
// item passes through an accept state and a decode state and then: fill sweeps every
// byte of the memory; point draw, point read and scan pixel run a read state and then
// a modify or sample state; glyph draws take each on-screen pixel through check, read
// and write-back states and skip a clipped pixel run in one check, since every pixel is
// a read-modify-write on the one memory port. A done state hands the result to the
// output register once it is free, and the next item is accepted while that result still waits.
// Colors for scan are set by fg_color (address 0) and bg_color (address 4).
module mono_framebuffer_text_render_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [9:0]  pos_x,
  input  wire logic [9:0]  pos_y,
  input  wire logic [6:0]  text_line,
  input  wire logic        pixel_value,
  input  wire logic [7:0]  char_code,
  input  wire logic [7:0]  scale,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             read_bit,
  output logic [15:0]      pixel,
  output logic             frame_end,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  mfb_pkg::cmd_t  cmd;
  mfb_pkg::stat_t st;
  logic [15:0]    fg_color, bg_color;

  assign pready = 1'b1;

  // Color registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= 16'hFFFF;
      bg_color <= 16'h0000;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == mfb_pkg::REG_FG) fg_color <= pwdata[15:0];
      else bg_color <= pwdata[15:0];
    end
  end

  // Register readback
  always_comb begin
    if (paddr[2] == mfb_pkg::REG_FG) prdata = {16'h0000, fg_color};
    else prdata = {16'h0000, bg_color};
  end

  mfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  mfb_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .opcode      (opcode),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .text_line   (text_line),
    .pixel_value (pixel_value),
    .char_code   (char_code),
    .scale       (scale),
    .fg_color    (fg_color),
    .bg_color    (bg_color),
    .read_bit    (read_bit),
    .pixel       (pixel),
    .frame_end   (frame_end)
  );

endmodule
`default_nettype wire

FILE: test/mono_framebuffer_text_render_unit_test.sv
// Self-checking testbench for the monochrome framebuffer text renderer.
`timescale 1ns / 1ps
module mono_framebuffer_text_render_unit_test;

  localparam int W = mfb_pkg::SCREEN_WIDTH;
  localparam int H = mfb_pkg::SCREEN_HEIGHT;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam logic [2:0] ADDR_FG = 3'd0;
  localparam logic [2:0] ADDR_BG = 3'd4;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic        read_bit;
    logic [15:0] pixel;
    logic        frame_end;
  } frame_result_t;

  // Font: six columns per glyph, column 0 in the top byte, bit r is glyph row r
  localparam logic [47:0] FONT [95] = '{
    48'h000000000000, 48'h00005F000000, 48'h000700070000, 48'h147F147F1400,
    48'h242A7F2A1200, 48'h231308646200, 48'h364955225000, 48'h000503000000,
    48'h001C22410000, 48'h0041221C0000, 48'h082A1C2A0800, 48'h08083E080800,
    48'h005030000000, 48'h080808080800, 48'h006060000000, 48'h201008040200,
    48'h3E5149453E00, 48'h00427F400000, 48'h426151494600, 48'h2141454B3100,
    48'h1814127F1000, 48'h274545453900, 48'h3C4A49493000, 48'h017109050300,
    48'h364949493600, 48'h064949291E00, 48'h003636000000, 48'h005636000000,
    48'h000814224100, 48'h141414141400, 48'h412214080000, 48'h020151090600,
    48'h324979413E00, 48'h7E1111117E00, 48'h7F4949493600, 48'h3E4141412200,
    48'h7F4141221C00, 48'h7F4949494100, 48'h7F0909010100, 48'h3E4141513200,
    48'h7F0808087F00, 48'h00417F410000, 48'h2040413F0100, 48'h7F0814224100,
    48'h7F4040404000, 48'h7F0204027F00, 48'h7F0408107F00, 48'h3E4141413E00,
    48'h7F0909090600, 48'h3E4151215E00, 48'h7F0919294600, 48'h464949493100,
    48'h01017F010100, 48'h3F4040403F00, 48'h1F2040201F00, 48'h7F2018207F00,
    48'h631408146300, 48'h030478040300, 48'h615149454300, 48'h00007F414100,
    48'h020408102000, 48'h41417F000000, 48'h040201020400, 48'h404040404000,
    48'h000102040000, 48'h205454547800, 48'h7F4844443800, 48'h384444442000,
    48'h384444487F00, 48'h385454541800, 48'h087E09010200, 48'h081454543C00,
    48'h7F0804047800, 48'h00447D400000, 48'h2040443D0000, 48'h007F10284400,
    48'h00417F400000, 48'h7C0418047800, 48'h7C0804047800, 48'h384444443800,
    48'h7C1414140800, 48'h081414187C00, 48'h7C0804040800, 48'h485454542000,
    48'h043F44402000, 48'h3C4040207C00, 48'h1C2040201C00, 48'h3C4030403C00,
    48'h442810284400, 48'h0C5050503C00, 48'h4464544C4400, 48'h000836410000,
    48'h00007F000000, 48'h004136080000, 48'h080408100800
  };

  // Shadow framebuffer plus queue of pending frame results
  class frame_scoreboard;
    bit            shadow [0:H-1][0:W-1];
    int            col, row;
    logic [15:0]   fg, bg;
    frame_result_t pending_q [$];
    int            errors, checked, frames;

    function new();
      foreach (shadow[y, x]) shadow[y][x] = 0;
      col = 0; row = 0; fg = 16'hFFFF; bg = 16'h0000;
      errors = 0; checked = 0; frames = 0;
    endfunction

    function void plot(int x, int y, bit v);
      if (x < W && y < H) shadow[y][x] = v;
    endfunction

    function bit peek(int x, int y);
      return (x < W && y < H) ? shadow[y][x] : 1'b0;
    endfunction

    function logic [7:0] font_col(int code, int c);
      logic [47:0] ent;
      if (code < 'h20 || code > 'h7E || c > 5) return 8'h00;
      ent = FONT[code - 'h20];
      return ent[47 - 8 * c -: 8];
    endfunction

    function void note_item(logic [2:0] op, int x, int y, int line, bit v, int code, int s);
      frame_result_t e;
      logic [7:0] bits;
      int top;
      e.read_bit = 0; e.pixel = 0; e.frame_end = 0;
      case (op)
        mfb_pkg::OP_FILL: foreach (shadow[yy, xx]) shadow[yy][xx] = v;
        mfb_pkg::OP_SET: plot(x, y, v);
        mfb_pkg::OP_GET: e.read_bit = peek(x, y);
        mfb_pkg::OP_LINE: begin
          top = line * 8;
          if (code >= 'h20 && code <= 'h7E && x + 6 <= W && top + 8 <= H) begin
            for (int c = 0; c < 6; c++) begin
              bits = font_col(code, c);
              for (int r = 0; r < 8; r++) plot(x + c, top + r, bits[r]);
            end
          end
        end
        mfb_pkg::OP_SCALED: begin
          if (s != 0) begin
            for (int c = 0; c < 6; c++) begin
              bits = font_col(code, c);
              for (int r = 0; r < 8; r++) begin
                for (int dy = 0; dy < s && y + r * s + dy < H; dy++)
                  for (int dx = 0; dx < s && x + c * s + dx < W; dx++)
                    plot(x + c * s + dx, y + r * s + dy, bits[r]);
              end
            end
          end
        end
        mfb_pkg::OP_SCAN: begin
          e.pixel = shadow[row][col] ? fg : bg;
          col++;
          if (col >= W) begin
            col = 0;
            row++;
            if (row >= H) begin
              row = 0;
              e.frame_end = 1;
              frames++;
            end
          end
        end
        default: ;
      endcase
      pending_q.push_back(e);
    endfunction

    function void check_result(logic rb, logic [15:0] px, logic fe);
      frame_result_t e;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (rb !== e.read_bit) begin
        $error("read_bit expected %0d actual %0d", e.read_bit, rb); errors++;
      end
      if (px !== e.pixel) begin
        $error("pixel expected %h actual %h", e.pixel, px); errors++;
      end
      if (fe !== e.frame_end) begin
        $error("frame_end expected %0d actual %0d", e.frame_end, fe); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [2:0] opcode;
  logic [9:0] pos_x, pos_y;
  logic [6:0] text_line;
  logic pixel_value;
  logic [7:0] char_code, scale;
  logic read_bit, frame_end;
  logic [15:0] pixel;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  frame_scoreboard sb;
  idle_mode_t mode;
  int items_sent;

  mono_framebuffer_text_render_unit DUT (
    .clk, .rst, .in_valid, .in_ready, .opcode, .pos_x, .pos_y, .text_line,
    .pixel_value, .char_code, .scale, .out_valid, .out_ready, .read_bit,
    .pixel, .frame_end, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(read_bit, pixel, frame_end);
  end

  // Stall the receiver according to the idle mode
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      case (mode)
        IDLE_RECV: out_ready = ($urandom_range(99) >= 67);
        IDLE_BOTH: out_ready = ($urandom_range(99) >= 8);
        default:   out_ready = 1;
      endcase
    end
  end

  task automatic send_item(logic [2:0] op, logic [9:0] x, logic [9:0] y, logic [6:0] line,
                           logic v, logic [7:0] code, logic [7:0] s);
    int idle_pct;
    idle_pct = (mode == IDLE_SEND) ? 67 : (mode == IDLE_BOTH) ? 8 : 0;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1; opcode = op; pos_x = x; pos_y = y; text_line = line;
    pixel_value = v; char_code = code; scale = s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(op, x, y, line, v, code, s);
    items_sent++;
  endtask

  // Hold the sender until every expected result is back
  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [15:0] value);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = addr; pwdata = {16'h0, value};
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_FG) sb.fg = value; else sb.bg = value;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic set_colors(logic [15:0] f, logic [15:0] b);
    drain();
    reg_write(ADDR_FG, f);
    reg_write(ADDR_BG, b);
  endtask

  task automatic random_item();
    int pick;
    logic [2:0] op;
    logic [9:0] x, y;
    logic [7:0] code, s;
    pick = $urandom_range(99);
    x = $urandom; y = $urandom;
    code = ($urandom_range(99) < 85) ? 8'($urandom_range('h7E, 'h20)) : 8'($urandom);
    s = 8'($urandom_range(4, 1));
    if (pick < 35) op = mfb_pkg::OP_SCAN;
    else if (pick < 50) op = mfb_pkg::OP_GET;
    else if (pick < 65) op = mfb_pkg::OP_SET;
    else if (pick < 80) op = mfb_pkg::OP_LINE;
    else if (pick < 95) op = mfb_pkg::OP_SCALED;
    else if (pick < 96) op = mfb_pkg::OP_FILL;
    else op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
    // Keep most coordinates on screen so the draws land
    if ($urandom_range(99) < 85) begin
      x = $urandom_range(W - 1);
      y = $urandom_range(H - 1);
    end
    if (op == mfb_pkg::OP_SCALED) begin
      pick = $urandom_range(99);
      if (pick < 3) s = 0;
      else if (pick < 5) s = $urandom;
    end
    send_item(op, x, y, 7'($urandom), 1'($urandom), code, s);
  endtask

  initial begin
    sb = new();
    mode = IDLE_NONE;
    items_sent = 0;
    rst = 1; in_valid = 0; opcode = 0; pos_x = 0; pos_y = 0; text_line = 0;
    pixel_value = 0; char_code = 0; scale = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (8) @(negedge clk);
    rst = 0;

    // Directed corners, clipping and glyph edge cases
    send_item(mfb_pkg::OP_GET, 0, 0, 0, 0, 0, 0);
    send_item(mfb_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0);
    send_item(mfb_pkg::OP_FILL, 0, 0, 0, 1, 0, 0);
    send_item(mfb_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0);
    send_item(mfb_pkg::OP_SET, 0, 0, 0, 0, 0, 0);
    send_item(mfb_pkg::OP_SET, W - 1, H - 1, 0, 0, 0, 0);
    send_item(mfb_pkg::OP_SET, W, 0, 0, 0, 0, 0);
    send_item(mfb_pkg::OP_SET, 1023, 1023, 0, 0, 0, 0);
    send_item(mfb_pkg::OP_GET, W - 1, H - 1, 0, 0, 0, 0);
    send_item(mfb_pkg::OP_GET, W, 0, 0, 0, 0, 0);
    send_item(mfb_pkg::OP_GET, 0, H, 0, 0, 0, 0);
    send_item(mfb_pkg::OP_FILL, 0, 0, 0, 0, 0, 0);
    send_item(mfb_pkg::OP_LINE, 0, 0, 0, 0, 8'h41, 0);
    send_item(mfb_pkg::OP_LINE, W - 6, 0, H / 8 - 1, 0, 8'h7E, 0);
    send_item(mfb_pkg::OP_LINE, W - 5, 0, 1, 0, 8'h42, 0);
    send_item(mfb_pkg::OP_LINE, 8, 0, H / 8, 0, 8'h42, 0);
    send_item(mfb_pkg::OP_LINE, 8, 0, 2, 0, 8'h1F, 0);
    send_item(mfb_pkg::OP_LINE, 8, 0, 2, 0, 8'hFF, 0);
    send_item(mfb_pkg::OP_SCALED, 20, 20, 0, 0, 8'h40, 0);
    send_item(mfb_pkg::OP_SCALED, 20, 20, 0, 0, 8'h40, 3);
    send_item(mfb_pkg::OP_SCALED, W - 4, H - 4, 0, 0, 8'h23, 2);
    send_item(mfb_pkg::OP_FILL, 0, 0, 0, 1, 0, 0);
    send_item(mfb_pkg::OP_SCALED, 30, 40, 0, 0, 8'h7F, 2);
    send_item(mfb_pkg::OP_SCALED, 0, 0, 0, 0, 8'h57, 255);
    send_item(OP_SPARE6, 1023, 1023, 127, 1, 255, 255);
    send_item(OP_SPARE7, 0, 0, 0, 0, 0, 0);

    // Scan across the first row and into the second
    set_colors(16'h0000, 16'hFFFF);
    send_item(mfb_pkg::OP_SCALED, 3, 5, 0, 0, 8'h26, 7);
    repeat (W + 28) send_item(mfb_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0);

    // Random phases with different idle patterns and color settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_colors(16'hFFFF, 16'h0000);
        1: set_colors(16'($urandom), 16'($urandom));
        2: set_colors(16'h0000, 16'h0000);
        default: set_colors(16'hFFFF, 16'hFFFF);
      endcase
      mode = idle_mode_t'(ph);
      repeat (400) random_item();
    end

    drain();
    mode = IDLE_NONE;
    repeat (50) @(negedge clk);
    if (sb.pending_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_q.size());
      sb.errors++;
    end
    $display("Ran %0d draw, read and scan items over four idle patterns and five color sets;",
             items_sent);
    $display("%0d results checked, %0d full frames scanned.", sb.checked, sb.frames);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
